// File: sv/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared widths, codes and reset values of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int PAGES_DEFAULT = 1024;

    localparam int FUNC_W   = 2;
    localparam int CNT_W    = 11;
    localparam int PAGE_W   = 10;
    localparam int STATUS_W = 3;
    localparam int PS_W     = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0] TOTAL_RESET  = 11'd1024;
    localparam logic [CNT_W-1:0] MAXREQ_RESET = 11'd512;

    localparam logic [0:0] CFG_IDX_TOTAL  = 1'b0;
    localparam logic [0:0] CFG_IDX_MAXREQ = 1'b1;

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RESV  = 2'd2;

    localparam logic [PS_W-1:0] PS_FREE  = 2'd0;
    localparam logic [PS_W-1:0] PS_ALLOC = 2'd1;
    localparam logic [PS_W-1:0] PS_RESV  = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NO_RUN    = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NO_REC    = 3'd4;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd5;
    localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 3'd6;

endpackage

// File: sv/contiguous_page_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator_top
// First-fit allocator of contiguous page runs over a map of PAGES entries.
// Page states and recorded run lengths sit in two RAMs with registered reads.
// After reset a clearing pass writes every entry free, during which no beat
// is taken (register writes still are). An allocate reads one page state a
// cycle from page 0 until a run is found, then writes the run one page a
// cycle; a scan that finds no run stops at the active limit. A free reads the
// run length, checks each page of the run and writes it back. A reserve
// writes count pages. Requests can be refused before any map access, a free
// also on its recorded length. Only one page-state entry is read or written a
// cycle. One request is in work at a time; a result waits in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_top #(
    parameter int PAGES = cpa_pkg::PAGES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cpa_pkg::S_TDATA_W-1:0]  s_tdata,   // page_count, start_page
    input  logic [cpa_pkg::FUNC_W-1:0]     s_tuser,   // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cpa_pkg::M_TDATA_W-1:0]  m_tdata,   // ok, result_page, status
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpa_pkg::APB_AW-1:0]     paddr,
    input  logic [cpa_pkg::APB_DW-1:0]     pwdata,
    output logic [cpa_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int AW = $clog2(PAGES);
    localparam int EW = (AW + 2 > 12) ? AW + 2 : 12;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                      state_reg, state_next;
    logic [EW-1:0]                   idx_reg, idx_next;
    logic [EW-1:0]                   end_reg, end_next;
    logic [EW-1:0]                   start_reg, start_next;
    logic [EW-1:0]                   didx_reg, didx_next;
    logic                            dv_reg, dv_next;
    logic [cpa_pkg::CNT_W-1:0]       run_reg, run_next;
    logic [cpa_pkg::FUNC_W-1:0]      func_reg, func_next;
    logic [cpa_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [cpa_pkg::PAGE_W-1:0]      sp_reg, sp_next;
    logic                            res_ok_reg, res_ok_next;
    logic [cpa_pkg::PAGE_W-1:0]      res_page_reg, res_page_next;
    logic [cpa_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            out_ok_reg;
    logic [cpa_pkg::PAGE_W-1:0]      out_page_reg;
    logic [cpa_pkg::STATUS_W-1:0]    out_status_reg;
    logic [cpa_pkg::CNT_W-1:0]       total_reg, maxreq_reg;

    logic                            load_out;
    logic                            scan_rd;
    logic                            cfg_wr;
    logic [0:0]                      cfg_idx;
    logic [EW-1:0]                   lim, sp_ext, cnt_ext, len_ext, run_start;

    logic                            st_we, st_re, ln_we, ln_re;
    logic [AW-1:0]                   st_waddr, st_raddr, ln_waddr, ln_raddr;
    logic [cpa_pkg::PS_W-1:0]        st_wdata, st_rdata;
    logic [cpa_pkg::CNT_W-1:0]       ln_wdata, ln_rdata;

    cpa_ram #(.WIDTH(cpa_pkg::PS_W), .DEPTH(PAGES)) u_state_ram (
        .clk   (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    cpa_ram #(.WIDTH(cpa_pkg::CNT_W), .DEPTH(PAGES)) u_len_ram (
        .clk   (aclk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .re    (ln_re),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[cpa_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            cpa_pkg::CFG_IDX_TOTAL:  prdata = cpa_pkg::APB_DW'(total_reg);
            cpa_pkg::CFG_IDX_MAXREQ: prdata = cpa_pkg::APB_DW'(maxreq_reg);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= cpa_pkg::TOTAL_RESET;
            maxreq_reg <= cpa_pkg::MAXREQ_RESET;
        end else if (cfg_wr) begin
            if (cfg_idx == cpa_pkg::CFG_IDX_TOTAL) begin
                total_reg <= pwdata[cpa_pkg::CNT_W-1:0];
            end else begin
                maxreq_reg <= pwdata[cpa_pkg::CNT_W-1:0];
            end
        end
    end

    assign lim       = (EW'(total_reg) < EW'(PAGES)) ? EW'(total_reg) : EW'(PAGES);
    assign sp_ext    = EW'(sp_reg);
    assign cnt_ext   = EW'(cnt_reg);
    assign len_ext   = EW'(ln_rdata);
    assign run_start = (run_reg == '0) ? didx_reg : start_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign scan_rd  = (state_reg == ST_SCAN) && (idx_reg < end_reg);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        start_next      = start_reg;
        didx_next       = didx_reg;
        dv_next         = 1'b0;
        run_next        = run_reg;
        func_next       = func_reg;
        cnt_next        = cnt_reg;
        sp_next         = sp_reg;
        res_ok_next     = res_ok_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;

        st_we    = 1'b0;
        st_waddr = idx_reg[AW-1:0];
        st_wdata = cpa_pkg::PS_FREE;
        st_re    = scan_rd;
        st_raddr = idx_reg[AW-1:0];
        ln_we    = 1'b0;
        ln_waddr = idx_reg[AW-1:0];
        ln_wdata = '0;
        ln_re    = 1'b0;
        ln_raddr = sp_ext[AW-1:0];

        case (state_reg)
            ST_CLEAR: begin
                st_we    = 1'b1;
                ln_we    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == EW'(PAGES - 1)) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser;
                    cnt_next   = s_tdata[cpa_pkg::CNT_W-1:0];
                    sp_next    = s_tdata[cpa_pkg::CNT_W +: cpa_pkg::PAGE_W];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                res_ok_next   = 1'b0;
                res_page_next = '0;
                state_next    = ST_DONE;
                case (func_reg)
                    cpa_pkg::FN_ALLOC: begin
                        if (cnt_reg == '0) begin
                            res_status_next = cpa_pkg::STS_ZERO;
                        end else if (cnt_reg > maxreq_reg) begin
                            res_status_next = cpa_pkg::STS_TOO_LARGE;
                        end else begin
                            idx_next   = '0;
                            end_next   = lim;
                            run_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    cpa_pkg::FN_FREE: begin
                        if (sp_ext >= lim) begin
                            res_status_next = cpa_pkg::STS_RANGE;
                        end else begin
                            ln_re      = 1'b1;
                            state_next = ST_LEN;
                        end
                    end
                    cpa_pkg::FN_RESV: begin
                        if (cnt_reg == '0) begin
                            res_status_next = cpa_pkg::STS_ZERO;
                        end else if (sp_ext >= lim || cnt_ext > lim - sp_ext) begin
                            res_status_next = cpa_pkg::STS_RANGE;
                        end else begin
                            idx_next   = sp_ext;
                            start_next = sp_ext;
                            end_next   = sp_ext + cnt_ext;
                            state_next = ST_WRITE;
                        end
                    end
                    default: begin
                        res_status_next = cpa_pkg::STS_RANGE;
                    end
                endcase
            end
            ST_LEN: begin
                state_next = ST_DONE;
                if (ln_rdata == '0) begin
                    res_status_next = cpa_pkg::STS_NO_REC;
                end else if (sp_ext + len_ext > lim) begin
                    res_status_next = cpa_pkg::STS_RANGE;
                end else begin
                    idx_next   = sp_ext;
                    start_next = sp_ext;
                    end_next   = sp_ext + len_ext;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                dv_next   = scan_rd;
                didx_next = idx_reg;
                if (scan_rd) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (dv_reg) begin
                    if (func_reg == cpa_pkg::FN_ALLOC) begin
                        if (st_rdata == cpa_pkg::PS_FREE) begin
                            start_next = run_start;
                            run_next   = run_reg + 1'b1;
                            if (run_reg + 1'b1 == cnt_reg) begin
                                idx_next   = run_start;
                                end_next   = run_start + cnt_ext;
                                dv_next    = 1'b0;
                                state_next = ST_WRITE;
                            end
                        end else begin
                            run_next = '0;
                        end
                    end else if (st_rdata != cpa_pkg::PS_ALLOC) begin
                        res_status_next = cpa_pkg::STS_NOT_ALLOC;
                        dv_next         = 1'b0;
                        state_next      = ST_DONE;
                    end
                end else if (!scan_rd) begin
                    if (func_reg == cpa_pkg::FN_ALLOC) begin
                        res_status_next = cpa_pkg::STS_NO_RUN;
                        state_next      = ST_DONE;
                    end else begin
                        idx_next   = start_reg;
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                st_we = 1'b1;
                case (func_reg)
                    cpa_pkg::FN_ALLOC: st_wdata = cpa_pkg::PS_ALLOC;
                    cpa_pkg::FN_FREE:  st_wdata = cpa_pkg::PS_FREE;
                    default:           st_wdata = cpa_pkg::PS_RESV;
                endcase
                ln_we    = (func_reg == cpa_pkg::FN_RESV) || (idx_reg == start_reg);
                ln_wdata = (func_reg == cpa_pkg::FN_ALLOC) ? cnt_reg : '0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == end_reg) begin
                    res_ok_next     = 1'b1;
                    res_status_next = cpa_pkg::STS_OK;
                    res_page_next   = (func_reg == cpa_pkg::FN_ALLOC) ?
                                      start_reg[cpa_pkg::PAGE_W-1:0] : '0;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_reg        <= end_next;
        start_reg      <= start_next;
        didx_reg       <= didx_next;
        run_reg        <= run_next;
        func_reg       <= func_next;
        cnt_reg        <= cnt_next;
        sp_reg         <= sp_next;
        res_ok_reg     <= res_ok_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        if (load_out) begin
            out_ok_reg     <= res_ok_reg;
            out_page_reg   <= res_page_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = cpa_pkg::M_TDATA_W'({out_status_reg, out_page_reg, out_ok_reg});

`ifndef NO_ASSERTIONS
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_we || ln_we) |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("map written outside clearing or write pass");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(st_we && st_re))
        else $error("page state read and written in the same cycle");

    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRITE |-> (idx_reg < end_reg && end_reg <= EW'(PAGES)))
        else $error("write pass outside the map");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_tready) |=> state_reg == ST_DONE)
        else $error("result left done state while output beat still pending");
`endif

endmodule

// File: sv/cpa_ram.sv
// ----------------------------------------------------------------------------
// cpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
